>>> rtl/stf_pkg.sv
package stf_pkg;

  // Coordinate format of both point sets: signed, 8 fraction bits.
  localparam int COORD_BITS = 24;
  localparam int CU_W       = COORD_BITS + 1;
  localparam int MUL_W      = 33;
  localparam int WORD_W     = 64;
  localparam int AB_W       = 63 - COORD_BITS;
  localparam int XY_W       = 34;
  localparam int Z_W        = 32;
  localparam int EXP_W      = 8;
  localparam int EXTRA_W    = 6;
  localparam int STEP_W     = 5;
  localparam int CORDIC_STEPS = 24;
  localparam int ROT_W      = 19;
  localparam int SCALE_W    = 24;
  localparam int STATUS_W   = 2;
  localparam int THRESH_W   = 16;

  localparam logic [WORD_W-1:0] AB_CAP    = 64'd1 << (61 - COORD_BITS);
  localparam logic [WORD_W-1:0] SCALE_MAX = 64'hFF_FFFF;
  localparam logic [WORD_W-1:0] NO_CAP    = '1;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 24'd65536;
  localparam logic signed [Z_W-1:0] ANGLE_PI = 32'sd52707179;
  localparam logic signed [Z_W-1:0] ANGLE_OUT_MAX = 32'sd205887;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
  localparam logic signed [EXP_W-1:0] EXP_INIT = 8'sd16;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] FIT_FULL  = 2'd0;
  localparam logic [STATUS_W-1:0] FIT_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] FIT_DEGEN = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] map_x;
    logic signed [COORD_BITS-1:0] map_y;
    logic signed [COORD_BITS-1:0] robot_x;
    logic signed [COORD_BITS-1:0] robot_y;
    logic                         last_pair;
  } pair_t;

  typedef struct packed {
    logic signed [ROT_W-1:0]      rotation;
    logic [SCALE_W-1:0]           scale;
    logic signed [COORD_BITS-1:0] shift_x;
    logic signed [COORD_BITS-1:0] shift_y;
    logic [STATUS_W-1:0]          fit_status;
  } fit_t;

  // Request to the shared divider: floor(num * 2^extra / den), capped.
  typedef struct packed {
    logic               start;
    logic [WORD_W-1:0]  num;
    logic [WORD_W-1:0]  den;
    logic [EXTRA_W-1:0] extra;
    logic [WORD_W-1:0]  cap;
  } div_req_t;

  typedef struct packed {
    logic                   start;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } cordic_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_READ,
    ST_CENTER,
    ST_SUM_MUL,
    ST_SUM_ACC,
    ST_CHECK,
    ST_AB_GO,
    ST_AB_WAIT,
    ST_TR_MUL,
    ST_TR_ACC,
    ST_ROUND,
    ST_NORM,
    ST_CORDIC_GO,
    ST_CORDIC_WAIT,
    ST_GAIN_MUL,
    ST_GAIN_ACC,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_OUT
  } state_t;

  // Arctangent of 2^-i with 24 fraction bits.
  function automatic logic signed [Z_W-1:0] cordic_atan(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = 32'sd13176795;
      5'd1:    r = 32'sd7778716;
      5'd2:    r = 32'sd4110060;
      5'd3:    r = 32'sd2086331;
      5'd4:    r = 32'sd1047214;
      5'd5:    r = 32'sd524117;
      5'd6:    r = 32'sd262123;
      5'd7:    r = 32'sd131069;
      5'd8:    r = 32'sd65536;
      5'd9:    r = 32'sd32768;
      5'd10:   r = 32'sd16384;
      5'd11:   r = 32'sd8192;
      5'd12:   r = 32'sd4096;
      5'd13:   r = 32'sd2048;
      5'd14:   r = 32'sd1024;
      5'd15:   r = 32'sd512;
      5'd16:   r = 32'sd256;
      5'd17:   r = 32'sd128;
      5'd18:   r = 32'sd64;
      5'd19:   r = 32'sd32;
      5'd20:   r = 32'sd16;
      5'd21:   r = 32'sd8;
      5'd22:   r = 32'sd4;
      5'd23:   r = 32'sd2;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to the coordinate width.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [WORD_W-1:0] v);
    logic signed [WORD_W-1:0] hi;
    logic signed [WORD_W-1:0] lo;
    logic signed [COORD_BITS-1:0] r;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      r = hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      r = lo[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/similarity_transform_fit_2d.sv
// Least-squares 2-D similarity fit: robot = s * R(theta) * map + t.
// Input channel pair (pair_valid, pair_stall): one map/robot point pair per
// item. While the block is idle, pairs load at one per cycle into the point
// store and running sums; pairs beyond MAX_POINTS are dropped, but an item
// with last_pair always ends a set and starts the fit, and pair_stall stays
// high until the result has been written into the output register.
// The fit uses the bit-serial divider (up to seven divisions) and the 24-step
// CORDIC; the centred sums use one shared multiplier, six products per pair.
// Output channel fit (fit_valid, fit_stall): one result item per set. The
// output register holds it while fit_stall is high; new pairs still load
// meanwhile, and a further fit waits for the register to empty.
// The user must write spread_threshold with spread_threshold_we only while
// the block is idle; the block has no check for it. Reset empties the store,
// clears the sums, empties the output register, sets the threshold to one.
module similarity_transform_fit_2d #(
  parameter int MAX_POINTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pair_valid,
  output logic                           pair_stall,
  input  stf_pkg::pair_t                 pair,
  output logic                           fit_valid,
  input  logic                           fit_stall,
  output stf_pkg::fit_t                  fit,
  input  logic                           spread_threshold_we,
  input  logic [stf_pkg::THRESH_W-1:0]   spread_threshold_data
);
  import stf_pkg::*;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int MEM_W  = 4 * COORD_BITS;

  state_t state;
  state_t state_next;

  logic [THRESH_W-1:0]          thresh;
  logic [CNT_W-1:0]             count;
  logic signed [SUM_W-1:0]      sums [4];
  logic signed [COORD_BITS-1:0] mean [4];
  logic signed [CU_W-1:0]       cu [4];
  logic [CNT_W-1:0]             idx;
  logic [2:0]                   k;
  logic [WORD_W-1:0]            su;
  logic [WORD_W-1:0]            pu;
  logic [WORD_W-1:0]            qu;
  logic [WORD_W-1:0]            pm;
  logic [WORD_W-1:0]            qm;
  logic [WORD_W-1:0]            big;
  logic                         neg_p;
  logic                         neg_q;
  logic signed [AB_W-1:0]       coef_a;
  logic signed [AB_W-1:0]       coef_b;
  logic signed [WORD_W-1:0]     tx;
  logic signed [WORD_W-1:0]     ty;
  logic signed [EXP_W-1:0]      expo;
  logic [WORD_W-1:0]            gain_m;
  fit_t                         res;

  logic [MEM_W-1:0]             mem [MAX_POINTS];
  logic [MEM_W-1:0]             rd_data;
  logic                         rd_en;

  logic                         accept;
  logic                         store_ok;
  logic signed [COORD_BITS-1:0] coord_in [4];
  logic signed [COORD_BITS-1:0] coord_rd [4];

  div_req_t                     div_req;
  logic                         div_done;
  logic [WORD_W-1:0]            div_quo;
  logic signed [MUL_W-1:0]      mul_a;
  logic signed [MUL_W-1:0]      mul_b;
  logic signed [WORD_W-1:0]     prod;
  cordic_req_t                  cord_req;
  logic                         cord_done;
  logic signed [XY_W-1:0]       cord_x;
  logic signed [Z_W-1:0]        cord_z;

  logic signed [WORD_W-1:0]     sum_k64;
  logic                         sum_neg;
  logic [WORD_W-1:0]            mean_q;
  logic                         degen;
  logic                         last_point;
  logic                         norm_hi;
  logic                         norm_lo;
  logic signed [MUL_W-1:0]      a_hi;
  logic signed [MUL_W-1:0]      a_lo;
  logic signed [MUL_W-1:0]      b_hi;
  logic signed [MUL_W-1:0]      b_lo;
  logic signed [MUL_W-1:0]      mmx_w;
  logic signed [MUL_W-1:0]      mmy_w;
  logic signed [Z_W-1:0]        z_round;
  logic [EXTRA_W-1:0]           rshift;

  stf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  stf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  stf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .req   (cord_req),
    .done  (cord_done),
    .x_out (cord_x),
    .z_out (cord_z)
  );

  // Input handshake and field unpacking.
  always_comb begin
    pair_stall  = (state != ST_IDLE);
    accept      = pair_valid && !pair_stall;
    store_ok    = (count < CNT_W'(MAX_POINTS));
    coord_in[0] = pair.map_x;
    coord_in[1] = pair.map_y;
    coord_in[2] = pair.robot_x;
    coord_in[3] = pair.robot_y;
    coord_rd[0] = rd_data[MEM_W-1 -: COORD_BITS];
    coord_rd[1] = rd_data[MEM_W-COORD_BITS-1 -: COORD_BITS];
    coord_rd[2] = rd_data[2*COORD_BITS-1 -: COORD_BITS];
    coord_rd[3] = rd_data[COORD_BITS-1:0];
  end

  // Shared helper values for the sequencer.
  always_comb begin
    sum_k64    = WORD_W'(sums[k[1:0]]);
    sum_neg    = sum_k64[WORD_W-1];
    mean_q     = sum_neg ? (64'd0 - div_quo) : div_quo;
    degen      = ($signed(su) < $signed({48'd0, thresh}));
    last_point = (idx == (count - CNT_W'(1)));
    norm_hi    = (big >= (64'd1 << 29));
    norm_lo    = (big < (64'd1 << 28));
    a_hi       = MUL_W'(coef_a >>> 16);
    a_lo       = {{(MUL_W-16){1'b0}}, coef_a[15:0]};
    b_hi       = MUL_W'(coef_b >>> 16);
    b_lo       = {{(MUL_W-16){1'b0}}, coef_b[15:0]};
    mmx_w      = MUL_W'(mean[0]);
    mmy_w      = MUL_W'(mean[1]);
    z_round    = (cord_z + 32'sd128) >>> 8;
    rshift     = EXTRA_W'(-expo);
  end

  // Next-state logic of the fit sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && pair.last_pair) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = (count < CNT_W'(2)) ? ST_OUT : ST_MEAN_GO;
      end
      ST_MEAN_GO: state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_next = (k == 3'd3) ? ST_READ : ST_MEAN_GO;
        end
      end
      ST_READ:    state_next = ST_CENTER;
      ST_CENTER:  state_next = ST_SUM_MUL;
      ST_SUM_MUL: state_next = ST_SUM_ACC;
      ST_SUM_ACC: begin
        if (k == 3'd5) begin
          state_next = last_point ? ST_CHECK : ST_READ;
        end else begin
          state_next = ST_SUM_MUL;
        end
      end
      ST_CHECK:  state_next = degen ? ST_OUT : ST_AB_GO;
      ST_AB_GO:  state_next = ST_AB_WAIT;
      ST_AB_WAIT: begin
        if (div_done) begin
          state_next = (k == 3'd1) ? ST_TR_MUL : ST_AB_GO;
        end
      end
      ST_TR_MUL: state_next = ST_TR_ACC;
      ST_TR_ACC: state_next = (k == 3'd7) ? ST_ROUND : ST_TR_MUL;
      ST_ROUND:  state_next = (big == '0) ? ST_OUT : ST_NORM;
      ST_NORM: begin
        if (!norm_hi && !norm_lo) begin
          state_next = ST_CORDIC_GO;
        end
      end
      ST_CORDIC_GO: state_next = ST_CORDIC_WAIT;
      ST_CORDIC_WAIT: begin
        if (cord_done) begin
          state_next = ST_GAIN_MUL;
        end
      end
      ST_GAIN_MUL: state_next = ST_GAIN_ACC;
      ST_GAIN_ACC: state_next = ST_SCALE_GO;
      ST_SCALE_GO: state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!fit_valid || !fit_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Requests to the shared units, decoded from the state and step.
  always_comb begin
    div_req  = '0;
    cord_req = '0;
    mul_a    = '0;
    mul_b    = '0;
    rd_en    = 1'b0;
    case (state)
      ST_MEAN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = sum_neg ? (64'd0 - sum_k64) : sum_k64;
        div_req.den   = WORD_W'(count);
        div_req.extra = '0;
        div_req.cap   = NO_CAP;
      end
      ST_READ: rd_en = 1'b1;
      ST_SUM_MUL: begin
        case (k)
          3'd0: begin mul_a = MUL_W'(cu[0]); mul_b = MUL_W'(cu[0]); end
          3'd1: begin mul_a = MUL_W'(cu[1]); mul_b = MUL_W'(cu[1]); end
          3'd2: begin mul_a = MUL_W'(cu[0]); mul_b = MUL_W'(cu[2]); end
          3'd3: begin mul_a = MUL_W'(cu[1]); mul_b = MUL_W'(cu[3]); end
          3'd4: begin mul_a = MUL_W'(cu[0]); mul_b = MUL_W'(cu[3]); end
          default: begin mul_a = MUL_W'(cu[1]); mul_b = MUL_W'(cu[2]); end
        endcase
      end
      ST_AB_GO: begin
        div_req.start = 1'b1;
        div_req.num   = (k == 3'd0) ? pm : qm;
        div_req.den   = su;
        div_req.extra = EXTRA_W'(16);
        div_req.cap   = AB_CAP;
      end
      ST_TR_MUL: begin
        case (k)
          3'd0: begin mul_a = a_hi; mul_b = mmx_w; end
          3'd1: begin mul_a = a_lo; mul_b = mmx_w; end
          3'd2: begin mul_a = b_hi; mul_b = mmy_w; end
          3'd3: begin mul_a = b_lo; mul_b = mmy_w; end
          3'd4: begin mul_a = b_hi; mul_b = mmx_w; end
          3'd5: begin mul_a = b_lo; mul_b = mmx_w; end
          3'd6: begin mul_a = a_hi; mul_b = mmy_w; end
          default: begin mul_a = a_lo; mul_b = mmy_w; end
        endcase
      end
      ST_CORDIC_GO: begin
        cord_req.start = 1'b1;
        cord_req.x     = neg_p ? -$signed({1'b0, pm[XY_W-2:0]})
                               : $signed({1'b0, pm[XY_W-2:0]});
        cord_req.y     = neg_q ? -$signed({1'b0, qm[XY_W-2:0]})
                               : $signed({1'b0, qm[XY_W-2:0]});
      end
      ST_GAIN_MUL: begin
        mul_a = $signed({1'b0, cord_x[31:0]});
        mul_b = $signed({3'b000, INV_GAIN_Q30});
      end
      ST_SCALE_GO: begin
        div_req.start = 1'b1;
        div_req.den   = su;
        div_req.cap   = SCALE_MAX;
        if (expo < 0) begin
          div_req.num   = gain_m >> rshift;
          div_req.extra = '0;
        end else begin
          div_req.num   = gain_m;
          div_req.extra = expo[EXTRA_W-1:0];
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Point store: written as pairs load, read one entry at a time by the fit.
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem[count[ADDR_W-1:0]] <= {pair.map_x, pair.map_y, pair.robot_x, pair.robot_y};
    end
    if (rd_en) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end
  end

  // Control state: sequencer, pair count, running sums, threshold, output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      thresh    <= THRESH_RESET;
      fit_valid <= 1'b0;
      for (int j = 0; j < 4; j++) begin
        sums[j] <= '0;
      end
    end else begin
      state <= state_next;
      if (spread_threshold_we) begin
        thresh <= spread_threshold_data;
      end
      if (accept && store_ok) begin
        count <= count + CNT_W'(1);
        for (int j = 0; j < 4; j++) begin
          sums[j] <= sums[j] + SUM_W'(coord_in[j]);
        end
      end
      if ((state == ST_OUT) && (!fit_valid || !fit_stall)) begin
        fit_valid <= 1'b1;
        count     <= '0;
        for (int j = 0; j < 4; j++) begin
          sums[j] <= '0;
        end
      end else if (fit_valid && !fit_stall) begin
        fit_valid <= 1'b0;
      end
    end
  end

  // Fit datapath, advanced one step per state.
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        k <= '0;
        res.rotation   <= '0;
        res.scale      <= SCALE_ONE;
        res.shift_x    <= '0;
        res.shift_y    <= '0;
        res.fit_status <= FIT_FEW;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean[k[1:0]] <= mean_q[COORD_BITS-1:0];
          k            <= k + 3'd1;
          idx          <= '0;
          su           <= '0;
          pu           <= '0;
          qu           <= '0;
        end
      end
      ST_CENTER: begin
        k <= '0;
        for (int j = 0; j < 4; j++) begin
          cu[j] <= CU_W'(coord_rd[j]) - CU_W'(mean[j]);
        end
      end
      ST_SUM_ACC: begin
        case (k)
          3'd0, 3'd1: su <= su + prod;
          3'd2, 3'd3: pu <= pu + prod;
          3'd4:       qu <= qu + prod;
          default:    qu <= qu - prod;
        endcase
        k <= k + 3'd1;
        if (k == 3'd5) begin
          idx <= idx + CNT_W'(1);
        end
      end
      ST_CHECK: begin
        k     <= '0;
        neg_p <= pu[WORD_W-1];
        neg_q <= qu[WORD_W-1];
        pm    <= pu[WORD_W-1] ? (64'd0 - pu) : pu;
        qm    <= qu[WORD_W-1] ? (64'd0 - qu) : qu;
        tx    <= WORD_W'(mean[2]) <<< 16;
        ty    <= WORD_W'(mean[3]) <<< 16;
        expo  <= EXP_INIT;
        res.rotation   <= '0;
        res.scale      <= SCALE_ONE;
        res.shift_x    <= sat_coord(WORD_W'(mean[2]) - WORD_W'(mean[0]));
        res.shift_y    <= sat_coord(WORD_W'(mean[3]) - WORD_W'(mean[1]));
        res.fit_status <= FIT_DEGEN;
      end
      ST_AB_WAIT: begin
        if (div_done) begin
          if (k == 3'd0) begin
            coef_a <= neg_p ? -$signed(div_quo[AB_W-1:0]) : $signed(div_quo[AB_W-1:0]);
            k      <= 3'd1;
          end else begin
            coef_b <= neg_q ? -$signed(div_quo[AB_W-1:0]) : $signed(div_quo[AB_W-1:0]);
            k      <= '0;
          end
          big <= (pm > qm) ? pm : qm;
        end
      end
      ST_TR_ACC: begin
        case (k)
          3'd0:    tx <= tx - (prod <<< 16);
          3'd1:    tx <= tx - prod;
          3'd2:    tx <= tx + (prod <<< 16);
          3'd3:    tx <= tx + prod;
          3'd4:    ty <= ty - (prod <<< 16);
          3'd5:    ty <= ty - prod;
          3'd6:    ty <= ty - (prod <<< 16);
          default: ty <= ty - prod;
        endcase
        k <= k + 3'd1;
      end
      ST_ROUND: begin
        res.shift_x    <= sat_coord((tx + 64'sd32768) >>> 16);
        res.shift_y    <= sat_coord((ty + 64'sd32768) >>> 16);
        res.fit_status <= FIT_FULL;
        res.rotation   <= '0;
        res.scale      <= '0;
      end
      ST_NORM: begin
        // Bring the larger magnitude into [2^28, 2^29), one bit per cycle.
        if (norm_hi) begin
          pm   <= pm >> 1;
          qm   <= qm >> 1;
          big  <= big >> 1;
          expo <= expo + EXP_W'(1);
        end else if (norm_lo) begin
          pm   <= pm << 1;
          qm   <= qm << 1;
          big  <= big << 1;
          expo <= expo - EXP_W'(1);
        end
      end
      ST_CORDIC_WAIT: begin
        if (cord_done) begin
          if (z_round > ANGLE_OUT_MAX) begin
            res.rotation <= ANGLE_OUT_MAX[ROT_W-1:0];
          end else if (z_round < -ANGLE_OUT_MAX) begin
            res.rotation <= ROT_W'(-ANGLE_OUT_MAX);
          end else begin
            res.rotation <= z_round[ROT_W-1:0];
          end
        end
      end
      ST_GAIN_ACC: begin
        gain_m <= (prod + (64'sd1 <<< 29)) >> 30;
      end
      ST_SCALE_WAIT: begin
        if (div_done) begin
          res.scale <= div_quo[SCALE_W-1:0];
        end
      end
      ST_OUT: begin
        if (!fit_valid || !fit_stall) begin
          fit <= res;
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule

>>> rtl/stf_div.sv
module stf_div (
  input  logic              clk,
  input  logic              rst,
  input  stf_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       quo
);
  import stf_pkg::*;

  logic              busy;
  logic [WORD_W-1:0] num_sh;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] q;
  logic [WORD_W-1:0] den;
  logic [WORD_W-1:0] cap;
  logic              ovf;
  logic [6:0]        cnt;
  logic [6:0]        last_cnt;
  logic [WORD_W:0]   rem2;
  logic              ge;

  // One quotient bit per cycle: shift in the next numerator bit, trial subtract.
  always_comb begin
    rem2 = {rem, num_sh[WORD_W-1]};
    ge   = (rem2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == last_cnt);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == last_cnt)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh   <= req.num;
      rem      <= '0;
      q        <= '0;
      ovf      <= 1'b0;
      den      <= req.den;
      cap      <= req.cap;
      cnt      <= '0;
      last_cnt <= 7'd63 + {1'b0, req.extra};
    end else if (busy) begin
      rem    <= ge ? WORD_W'(rem2 - {1'b0, den}) : rem2[WORD_W-1:0];
      q      <= {q[WORD_W-2:0], ge};
      ovf    <= ovf | q[WORD_W-1];
      num_sh <= {num_sh[WORD_W-2:0], 1'b0};
      cnt    <= cnt + 7'd1;
    end
  end

  // Quotients that overflow the register or pass the cap saturate.
  assign quo = (ovf || (q > cap)) ? cap : q;

endmodule

>>> rtl/stf_mul.sv
module stf_mul (
  input  logic                              clk,
  input  logic signed [stf_pkg::MUL_W-1:0]  a,
  input  logic signed [stf_pkg::MUL_W-1:0]  b,
  output logic signed [stf_pkg::WORD_W-1:0] prod
);
  import stf_pkg::*;

  logic signed [2*MUL_W-1:0] full;

  // Signed product, registered, kept to the accumulator width.
  assign full = a * b;

  always_ff @(posedge clk) begin
    prod <= full[WORD_W-1:0];
  end

endmodule

>>> rtl/stf_cordic.sv
module stf_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  stf_pkg::cordic_req_t            req,
  output logic                            done,
  output logic signed [stf_pkg::XY_W-1:0] x_out,
  output logic signed [stf_pkg::Z_W-1:0]  z_out
);
  import stf_pkg::*;

  logic                   busy;
  logic [STEP_W-1:0]      step;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   last_step;

  always_comb begin
    dx        = y >>> step;
    dy        = x >>> step;
    last_step = (step == STEP_W'(CORDIC_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last_step;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
      end
    end
  end

  // Vectoring mode: fold the left half-plane over, then rotate y towards zero.
  always_ff @(posedge clk) begin
    if (req.start) begin
      step <= '0;
      if (req.x < 0) begin
        x <= -req.x;
        y <= -req.y;
        z <= (req.y >= 0) ? ANGLE_PI : -ANGLE_PI;
      end else begin
        x <= req.x;
        y <= req.y;
        z <= '0;
      end
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + cordic_atan(step);
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - cordic_atan(step);
      end
    end
  end

  assign x_out = x;
  assign z_out = z;

endmodule
